@@ src/iou_pkg.sv @@
// ----------------------------------------------------------------------------
// iou_pkg
// Shared types and default sizes for the box intersection-over-union pipeline.
// ----------------------------------------------------------------------------
package iou_pkg;

   // Default coordinate width (two's complement) and fraction width of the ratio
   localparam int unsigned COORD_BITS_DEF = 16;
   localparam int unsigned FRAC_BITS_DEF  = 16;

   // Control that travels with each beat down the pipeline
   typedef struct packed {
      logic valid;
      logic hit;
   } iou_ctl_type;

endpackage
// ----------------------------------------------------------------------------

@@ src/iou_geom.sv @@
// ----------------------------------------------------------------------------
// iou_geom
// First stage: box widths and heights clamped at zero, and the overlap extent.
// ----------------------------------------------------------------------------
module iou_geom #(
   parameter int unsigned COORD_BITS = iou_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] a_left,
   input  logic signed [COORD_BITS-1:0] a_top,
   input  logic signed [COORD_BITS-1:0] a_right,
   input  logic signed [COORD_BITS-1:0] a_bottom,
   input  logic signed [COORD_BITS-1:0] b_left,
   input  logic signed [COORD_BITS-1:0] b_top,
   input  logic signed [COORD_BITS-1:0] b_right,
   input  logic signed [COORD_BITS-1:0] b_bottom,
   output iou_pkg::iou_ctl_type         ctl,
   output logic [COORD_BITS-1:0]        wid_a,
   output logic [COORD_BITS-1:0]        hgt_a,
   output logic [COORD_BITS-1:0]        wid_b,
   output logic [COORD_BITS-1:0]        hgt_b,
   output logic [COORD_BITS-1:0]        wid_i,
   output logic [COORD_BITS-1:0]        hgt_i
);

   localparam int unsigned C = COORD_BITS;

   // hi - lo when positive, else zero; the result always fits in C bits
   function automatic logic [C-1:0] span(input logic signed [C-1:0] lo,
                                         input logic signed [C-1:0] hi);
      logic [C:0] d;
      begin
         d = {hi[C-1], hi} - {lo[C-1], lo};
         span = (!d[C] && (d != '0)) ? d[C-1:0] : '0;
      end
   endfunction

   logic signed [C-1:0] x1, y1, x2, y2;
   iou_pkg::iou_ctl_type ctl_in, ctl_ff;
   logic [C-1:0] wid_a_in, hgt_a_in, wid_b_in, hgt_b_in, wid_i_in, hgt_i_in;
   logic [C-1:0] wid_a_ff, hgt_a_ff, wid_b_ff, hgt_b_ff, wid_i_ff, hgt_i_ff;

   always_comb begin
      x1 = (a_left > b_left) ? a_left : b_left;
      y1 = (a_top > b_top) ? a_top : b_top;
      x2 = (a_right < b_right) ? a_right : b_right;
      y2 = (a_bottom < b_bottom) ? a_bottom : b_bottom;

      wid_a_in = span(a_left, a_right);
      hgt_a_in = span(a_top, a_bottom);
      wid_b_in = span(b_left, b_right);
      hgt_b_in = span(b_top, b_bottom);
      wid_i_in = span(x1, x2);
      hgt_i_in = span(y1, y2);

      ctl_in.valid = in_valid;
      ctl_in.hit   = (wid_i_in != '0) && (hgt_i_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      wid_a_ff <= wid_a_in;
      hgt_a_ff <= hgt_a_in;
      wid_b_ff <= wid_b_in;
      hgt_b_ff <= hgt_b_in;
      wid_i_ff <= wid_i_in;
      hgt_i_ff <= hgt_i_in;
   end

   assign ctl   = ctl_ff;
   assign wid_a = wid_a_ff;
   assign hgt_a = hgt_a_ff;
   assign wid_b = wid_b_ff;
   assign hgt_b = hgt_b_ff;
   assign wid_i = wid_i_ff;
   assign hgt_i = hgt_i_ff;

endmodule
// ----------------------------------------------------------------------------

@@ src/iou_area.sv @@
// ----------------------------------------------------------------------------
// iou_area
// Two stages: the three area products, then the union of the two boxes.
// ----------------------------------------------------------------------------
module iou_area #(
   parameter int unsigned COORD_BITS = iou_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  iou_pkg::iou_ctl_type        in_ctl,
   input  logic [COORD_BITS-1:0]       wid_a,
   input  logic [COORD_BITS-1:0]       hgt_a,
   input  logic [COORD_BITS-1:0]       wid_b,
   input  logic [COORD_BITS-1:0]       hgt_b,
   input  logic [COORD_BITS-1:0]       wid_i,
   input  logic [COORD_BITS-1:0]       hgt_i,
   output iou_pkg::iou_ctl_type        out_ctl,
   output logic [2*COORD_BITS-1:0]     inter,
   output logic [2*COORD_BITS:0]       uni
);

   localparam int unsigned A = 2 * COORD_BITS;

   iou_pkg::iou_ctl_type mul_ctl_ff, sum_ctl_ff;
   logic [A-1:0] area_a_in, area_b_in, area_i_in;
   logic [A-1:0] area_a_ff, area_b_ff, area_i_ff;
   logic [A:0]   uni_in, uni_ff;
   logic [A-1:0] inter_ff;

   always_comb begin
      area_a_in = A'(wid_a) * A'(hgt_a);
      area_b_in = A'(wid_b) * A'(hgt_b);
      area_i_in = A'(wid_i) * A'(hgt_i);
      // union never drops below the overlap, so no wrap here
      uni_in    = (A+1)'(area_a_ff) + (A+1)'(area_b_ff) - (A+1)'(area_i_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ctl_ff <= '0;
         sum_ctl_ff <= '0;
      end else begin
         mul_ctl_ff <= in_ctl;
         sum_ctl_ff <= mul_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      area_a_ff <= area_a_in;
      area_b_ff <= area_b_in;
      area_i_ff <= area_i_in;
      uni_ff    <= uni_in;
      inter_ff  <= area_i_ff;
   end

   assign out_ctl = sum_ctl_ff;
   assign inter   = inter_ff;
   assign uni     = uni_ff;

endmodule
// ----------------------------------------------------------------------------

@@ src/iou_div.sv @@
// ----------------------------------------------------------------------------
// iou_div
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS+1 stages,
// giving floor(num * 2^FRAC_BITS / den) for num <= den.
// ----------------------------------------------------------------------------
module iou_div #(
   parameter int unsigned NUM_BITS  = 2 * iou_pkg::COORD_BITS_DEF,
   parameter int unsigned FRAC_BITS = iou_pkg::FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  iou_pkg::iou_ctl_type   in_ctl,
   input  logic [NUM_BITS-1:0]    num,
   input  logic [NUM_BITS:0]      den,
   output iou_pkg::iou_ctl_type   out_ctl,
   output logic [FRAC_BITS:0]     quo
);

   localparam int unsigned RW     = NUM_BITS + 1;   // remainder stays below den
   localparam int unsigned STAGES = FRAC_BITS + 1;

   iou_pkg::iou_ctl_type ctl_in [STAGES];
   iou_pkg::iou_ctl_type ctl_ff [STAGES];
   logic [RW:0]          trial  [STAGES];
   logic [RW:0]          diff   [STAGES];
   logic [STAGES-1:0]    take;
   logic [RW-1:0]        den_in [STAGES];
   logic [RW-1:0]        den_ff [STAGES];
   logic [RW-1:0]        rem_in [STAGES];
   logic [RW-1:0]        rem_ff [STAGES];
   logic [FRAC_BITS:0]   quo_in [STAGES];
   logic [FRAC_BITS:0]   quo_ff [STAGES];

   always_comb begin
      ctl_in[0] = in_ctl;
      den_in[0] = den;
      trial[0]  = (RW+1)'(num);
      for (int k = 1; k < STAGES; k++) begin
         ctl_in[k] = ctl_ff[k-1];
         den_in[k] = den_ff[k-1];
         trial[k]  = {rem_ff[k-1], 1'b0};
      end
      // subtract the divisor wherever the shifted remainder covers it
      for (int k = 0; k < STAGES; k++) begin
         diff[k]   = trial[k] - {1'b0, den_in[k]};
         take[k]   = !diff[k][RW];
         rem_in[k] = take[k] ? diff[k][RW-1:0] : trial[k][RW-1:0];
      end
      quo_in[0] = {{FRAC_BITS{1'b0}}, take[0]};
      for (int k = 1; k < STAGES; k++) begin
         quo_in[k] = {quo_ff[k-1][FRAC_BITS-1:0], take[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++)
            ctl_ff[k] <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++)
            ctl_ff[k] <= ctl_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < STAGES; k++) begin
         den_ff[k] <= den_in[k];
         rem_ff[k] <= rem_in[k];
         quo_ff[k] <= quo_in[k];
      end
   end

   assign out_ctl = ctl_ff[STAGES-1];
   assign quo     = quo_ff[STAGES-1];

endmodule
// ----------------------------------------------------------------------------

@@ src/box_iou.sv @@
// ----------------------------------------------------------------------------
// box_iou
// Intersection over union of two axis-aligned integer boxes, Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
// A box pair is taken on every cycle that start is high; busy never rises.
// Each pair gives one result, shown for a single cycle with rsp_valid high;
// the receiver cannot hold it, so it must capture the beat in that cycle.
// The pair passes a span stage, a product stage, a union stage, the divider,
// which resolves one quotient bit per stage, and the output register.
// rsp_overlap_ratio is floor(inter * 2^FRAC_BITS / union), 2^FRAC_BITS for
// identical non-empty boxes; both outputs are zero when the boxes do not overlap.
// ----------------------------------------------------------------------------
module box_iou #(
   parameter int unsigned COORD_BITS = iou_pkg::COORD_BITS_DEF,
   parameter int unsigned FRAC_BITS  = iou_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_a_left,
   input  logic signed [COORD_BITS-1:0] req_a_top,
   input  logic signed [COORD_BITS-1:0] req_a_right,
   input  logic signed [COORD_BITS-1:0] req_a_bottom,
   input  logic signed [COORD_BITS-1:0] req_b_left,
   input  logic signed [COORD_BITS-1:0] req_b_top,
   input  logic signed [COORD_BITS-1:0] req_b_right,
   input  logic signed [COORD_BITS-1:0] req_b_bottom,
   output logic                         rsp_valid,
   output logic [FRAC_BITS:0]           rsp_overlap_ratio,
   output logic                         rsp_has_overlap
);

   localparam int unsigned C = COORD_BITS;
   localparam int unsigned A = 2 * COORD_BITS;

   iou_pkg::iou_ctl_type geom_ctl, area_ctl, div_ctl;
   logic [C-1:0]       wid_a, hgt_a, wid_b, hgt_b, wid_i, hgt_i;
   logic [A-1:0]       inter;
   logic [A:0]         uni;
   logic [FRAC_BITS:0] quo;

   logic               valid_ff, valid_in;
   logic               hit_ff, hit_in;
   logic [FRAC_BITS:0] ratio_ff, ratio_in;

   // the pipeline never stalls
   assign busy = 1'b0;

   iou_geom #(
      .COORD_BITS (COORD_BITS)
   ) u_geom (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .a_left   (req_a_left),
      .a_top    (req_a_top),
      .a_right  (req_a_right),
      .a_bottom (req_a_bottom),
      .b_left   (req_b_left),
      .b_top    (req_b_top),
      .b_right  (req_b_right),
      .b_bottom (req_b_bottom),
      .ctl      (geom_ctl),
      .wid_a    (wid_a),
      .hgt_a    (hgt_a),
      .wid_b    (wid_b),
      .hgt_b    (hgt_b),
      .wid_i    (wid_i),
      .hgt_i    (hgt_i)
   );

   iou_area #(
      .COORD_BITS (COORD_BITS)
   ) u_area (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (geom_ctl),
      .wid_a   (wid_a),
      .hgt_a   (hgt_a),
      .wid_b   (wid_b),
      .hgt_b   (hgt_b),
      .wid_i   (wid_i),
      .hgt_i   (hgt_i),
      .out_ctl (area_ctl),
      .inter   (inter),
      .uni     (uni)
   );

   iou_div #(
      .NUM_BITS  (A),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .in_ctl  (area_ctl),
      .num     (inter),
      .den     (uni),
      .out_ctl (div_ctl),
      .quo     (quo)
   );

   always_comb begin
      valid_in = div_ctl.valid;
      hit_in   = div_ctl.hit;
      // drop the quotient when there is no overlap
      ratio_in = div_ctl.hit ? quo : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff   <= hit_in;
      ratio_ff <= ratio_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_has_overlap   = hit_ff;
   assign rsp_overlap_ratio = ratio_ff;

endmodule
// ----------------------------------------------------------------------------

@@ tb/sv/box_iou_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_iou_tb
// Drives box pairs into box_iou and checks every ratio and overlap flag
// against a local integer prediction: directed corner pairs first, then
// random pairs under three sender idle settings.
// ----------------------------------------------------------------------------
module box_iou_tb;

   localparam int unsigned COORD_W     = iou_pkg::COORD_BITS_DEF;
   localparam int unsigned FRAC_W      = iou_pkg::FRAC_BITS_DEF;
   localparam int unsigned LATENCY     = FRAC_W + 5;
   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int unsigned MAX_REPORTS = 10;
   localparam longint      COORD_MIN   = -(64'sd1 <<< (COORD_W - 1));
   localparam longint      COORD_MAX   = (64'sd1 <<< (COORD_W - 1)) - 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] a_left;
      logic signed [COORD_W-1:0] a_top;
      logic signed [COORD_W-1:0] a_right;
      logic signed [COORD_W-1:0] a_bottom;
      logic signed [COORD_W-1:0] b_left;
      logic signed [COORD_W-1:0] b_top;
      logic signed [COORD_W-1:0] b_right;
      logic signed [COORD_W-1:0] b_bottom;
   } box_pair_type;

   typedef struct packed {
      logic [FRAC_W:0] ratio;
      logic            hit;
   } iou_result_type;

   class iou_scoreboard;
      iou_result_type pending_ratios[$];
      int unsigned errors;

      function new();
         errors = 0;
      endfunction

      static function longint extent(longint lo, longint hi);
         return (hi > lo) ? hi - lo : 0;
      endfunction

      function iou_result_type predict_iou(box_pair_type p);
         iou_result_type r;
         longint al, at, ar, ab, bl, bt, br, bb;
         longint x1, y1, x2, y2;
         longint unsigned area_a, area_b, inter, uni, q;
         al = p.a_left;  at = p.a_top;  ar = p.a_right;  ab = p.a_bottom;
         bl = p.b_left;  bt = p.b_top;  br = p.b_right;  bb = p.b_bottom;
         area_a = extent(al, ar) * extent(at, ab);
         area_b = extent(bl, br) * extent(bt, bb);
         x1 = (al > bl) ? al : bl;
         y1 = (at > bt) ? at : bt;
         x2 = (ar < br) ? ar : br;
         y2 = (ab < bb) ? ab : bb;
         if (x1 >= x2 || y1 >= y2) begin
            r.ratio = '0;
            r.hit   = 1'b0;
         end else begin
            inter   = (x2 - x1) * (y2 - y1);
            uni     = area_a + area_b - inter;
            q       = (inter << FRAC_W) / uni;
            r.ratio = q[FRAC_W:0];
            r.hit   = 1'b1;
         end
         return r;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
      endfunction

      function void note_pair(box_pair_type p);
         pending_ratios.push_back(predict_iou(p));
      endfunction

      function void check_result(logic [FRAC_W:0] ratio, logic hit);
         iou_result_type want;
         if (pending_ratios.size() == 0) begin
            flag($sformatf("result beat with no pair pending: ratio=%0d hit=%0b",
                           ratio, hit));
            return;
         end
         want = pending_ratios.pop_front();
         if (ratio !== want.ratio)
            flag($sformatf("overlap_ratio mismatch: expected %0d, got %0d",
                           want.ratio, ratio));
         if (hit !== want.hit)
            flag($sformatf("has_overlap mismatch: expected %0b, got %0b",
                           want.hit, hit));
      endfunction

      function int unsigned outstanding();
         return pending_ratios.size();
      endfunction

      function void close_out();
         if (pending_ratios.size() != 0)
            flag($sformatf("%0d results never arrived", pending_ratios.size()));
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   box_pair_type    req_beat = '0;
   logic            rsp_valid;
   logic [FRAC_W:0] rsp_overlap_ratio;
   logic            rsp_has_overlap;

   int unsigned     taken_count = 0;
   int unsigned     cycle_count = 0;
   iou_scoreboard   sb = new();

   always #1 clock = ~clock;

   box_iou uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_a_left        (req_beat.a_left),
      .req_a_top         (req_beat.a_top),
      .req_a_right       (req_beat.a_right),
      .req_a_bottom      (req_beat.a_bottom),
      .req_b_left        (req_beat.b_left),
      .req_b_top         (req_beat.b_top),
      .req_b_right       (req_beat.b_right),
      .req_b_bottom      (req_beat.b_bottom),
      .rsp_valid         (rsp_valid),
      .rsp_overlap_ratio (rsp_overlap_ratio),
      .rsp_has_overlap   (rsp_has_overlap)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid)
            sb.check_result(rsp_overlap_ratio, rsp_has_overlap);
         if (start && !busy) begin
            sb.note_pair(req_beat);
            taken_count <= taken_count + 1;
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic longint rand_between(longint lo, longint hi);
      return lo + longint'($urandom_range(0, 32'(hi - lo)));
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
      if (v < COORD_MIN) return COORD_W'(COORD_MIN);
      if (v > COORD_MAX) return COORD_W'(COORD_MAX);
      return COORD_W'(v);
   endfunction

   function automatic box_pair_type pair_of(longint al, longint at, longint ar, longint ab,
                                            longint bl, longint bt, longint br, longint bb);
      box_pair_type p;
      p.a_left = clamp_coord(al);  p.a_top = clamp_coord(at);
      p.a_right = clamp_coord(ar); p.a_bottom = clamp_coord(ab);
      p.b_left = clamp_coord(bl);  p.b_top = clamp_coord(bt);
      p.b_right = clamp_coord(br); p.b_bottom = clamp_coord(bb);
      return p;
   endfunction

   // Mostly well-formed pairs near each other so that overlaps are common;
   // the rest are identical boxes, inverted edges and raw noise.
   function automatic box_pair_type make_pair();
      box_pair_type              p;
      logic signed [COORD_W-1:0] hold;
      int unsigned               mode;
      longint                    reach, al, at, bl, bt;
      mode = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0:       reach = 8;
         1:       reach = 256;
         2:       reach = 4096;
         default: reach = 65535;
      endcase
      al = rand_between(COORD_MIN, COORD_MAX - 1);
      at = rand_between(COORD_MIN, COORD_MAX - 1);
      bl = al + rand_between(-reach, reach);
      bt = at + rand_between(-reach, reach);
      p = pair_of(al, at, al + rand_between(1, reach), at + rand_between(1, reach),
                  bl, bt, bl + rand_between(1, reach), bt + rand_between(1, reach));
      if (mode < 8) begin
         p.b_left = p.a_left;   p.b_top = p.a_top;
         p.b_right = p.a_right; p.b_bottom = p.a_bottom;
      end else if (mode < 20) begin
         case ($urandom_range(0, 3))
            0:       begin hold = p.a_left; p.a_left = p.a_right; p.a_right = hold; end
            1:       begin hold = p.a_top; p.a_top = p.a_bottom; p.a_bottom = hold; end
            2:       begin hold = p.b_left; p.b_left = p.b_right; p.b_right = hold; end
            default: begin hold = p.b_top; p.b_top = p.b_bottom; p.b_bottom = hold; end
         endcase
      end else if (mode < 34) begin
         p = box_pair_type'({$urandom, $urandom, $urandom, $urandom});
      end
      return p;
   endfunction

   task automatic send_pair(input box_pair_type p);
      int unsigned target;
      @(negedge clock);
      req_beat <= p;
      start    <= 1'b1;
      target = taken_count + 1;
      wait (taken_count == target);
   endtask

   task automatic idle_cycle();
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic drain();
      idle_cycle();
      while (sb.outstanding() != 0)
         @(posedge clock);
   endtask

   task automatic run_random(int unsigned count, int unsigned idle_pct);
      repeat (count) begin
         while ($urandom_range(0, 99) < idle_pct)
            idle_cycle();
         send_pair(make_pair());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identical boxes, unit and full range
      send_pair(pair_of(0, 0, 1, 1, 0, 0, 1, 1));
      send_pair(pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                        COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      // every field at one extreme
      send_pair(pair_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
      send_pair(pair_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                        COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      // touching edges give no overlap
      send_pair(pair_of(0, 0, 10, 10, 10, 0, 20, 10));
      send_pair(pair_of(0, 0, 10, 10, 0, 10, 10, 20));
      // inverted boxes
      send_pair(pair_of(10, 10, 0, 0, 0, 0, 10, 10));
      send_pair(pair_of(0, 0, 10, 10, 0, 10, 10, 0));
      send_pair(pair_of(100, 100, -100, -100, -10, -10, 10, 10));
      send_pair(pair_of(-10, -10, 10, 10, 10, -10, -10, 10));
      // zero-width box
      send_pair(pair_of(5, 0, 5, 10, 0, 0, 10, 10));
      // nested, partial and negative-coordinate overlaps
      send_pair(pair_of(-100, -100, 100, 100, -10, -10, 10, 10));
      send_pair(pair_of(0, 0, 2, 1, 1, 0, 3, 1));
      send_pair(pair_of(-5, -5, -1, -1, -3, -3, 0, 0));
      send_pair(pair_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0, 1, 1));
      // single-cell overlap of two huge boxes rounds to zero but still hits
      send_pair(pair_of(COORD_MIN, COORD_MIN, 0, 0, -1, -1, COORD_MAX, COORD_MAX));
      send_pair(pair_of(COORD_MIN, 0, COORD_MAX, 1, 0, COORD_MIN, 1, COORD_MAX));
      // disjoint, far apart
      send_pair(pair_of(COORD_MIN, COORD_MIN, -30000, -30000,
                        30000, 30000, COORD_MAX, COORD_MAX));

      run_random(630, 36);
      drain();
      run_random(630, 48);
      drain();
      run_random(640, 0);
      drain();

      repeat (2 * LATENCY) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
// ----------------------------------------------------------------------------
